// ===== sv/elx_pkg.sv =====
// Shared types and constants for the expression lexer.
// Used by every module of the lexer; depends on nothing.
`default_nettype none

package elx_pkg;

  // Pending run class
  typedef enum logic [1:0] {
    RUN_NONE  = 2'd0,
    RUN_NUM   = 2'd1,
    RUN_LOWER = 2'd2,
    RUN_UPPER = 2'd3
  } run_mode_t;

  // Token kinds as seen on the result port
  typedef enum logic [3:0] {
    TK_LPAREN   = 4'd0,
    TK_RPAREN   = 4'd1,
    TK_MUL      = 4'd2,
    TK_DIV      = 4'd3,
    TK_ADD      = 4'd4,
    TK_SUB      = 4'd5,
    TK_MOD      = 4'd6,
    TK_ASSIGN   = 4'd7,
    TK_NUMBER   = 4'd8,
    TK_PRINT    = 4'd9,
    TK_READ     = 4'd10,
    TK_VARIABLE = 4'd11,
    TK_FUNCTION = 4'd12,
    TK_ERROR    = 4'd13
  } token_kind_t;

  localparam int VALUE_W = 31;
  localparam int NAME_W  = 64;
  localparam int LEN_W   = 4;
  localparam int LINE_W  = 16;

  // Character codes
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_EQ     = 8'h3D;

  // Keywords packed first byte low
  localparam logic [NAME_W-1:0] KW_PRINT     = 64'h0000_0074_6E69_7270;
  localparam logic [NAME_W-1:0] KW_READ      = 64'h0000_0000_6461_6572;
  localparam logic [LEN_W-1:0]  KW_PRINT_LEN = 4'd5;
  localparam logic [LEN_W-1:0]  KW_READ_LEN  = 4'd4;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
  localparam logic [3:0]         RADIX     = 4'd10;

  // Token queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    token_kind_t         kind;
    logic [VALUE_W-1:0]  value;
    logic [NAME_W-1:0]   name;
    logic [LEN_W-1:0]    len;
    logic                trunc;
    logic                ovf;
    logic [LINE_W-1:0]   line;
    logic                last;
  } token_t;

  // Front to queue: up to two tokens per word
  typedef struct packed {
    logic   push0;
    logic   push1;
    token_t tok0;
    token_t tok1;
  } push_t;

  // Queue status back to front and back end
  typedef struct packed {
    logic room2;
    logic not_empty;
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== sv/elx_front.sv =====
// Front end: classifies each byte, keeps the pending run and the line
// counter, and produces up to two tokens per word. Uses elx_pkg.
`default_nettype none

module elx_front #(
  parameter int MAX_NAME_CHARS = 8,
  parameter int LINE_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char_code,
  input  logic                in_end_of_source,
  input  elx_pkg::queue_stat_t q_stat,
  output elx_pkg::push_t      push
);

  localparam int NB = 8 * MAX_NAME_CHARS;
  localparam int LW = (LINE_BITS < elx_pkg::LINE_W) ? LINE_BITS : elx_pkg::LINE_W;

  // Run state
  elx_pkg::run_mode_t          mode_r, mode_nxt;
  logic [elx_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [NB-1:0]               buf_r, buf_nxt;
  logic [elx_pkg::LEN_W-1:0]   cnt_r, cnt_nxt;
  logic                        trunc_r, trunc_nxt;
  logic [LW-1:0]               line_r, line_nxt;

  // State after this byte, before the end-of-source flush
  elx_pkg::run_mode_t          mid_mode;
  logic [elx_pkg::VALUE_W-1:0] mid_acc;
  logic                        mid_ovf;
  logic [NB-1:0]               mid_buf;
  logic [elx_pkg::LEN_W-1:0]   mid_cnt;
  logic                        mid_trunc;

  logic                        accept;
  elx_pkg::run_mode_t          cls;
  logic                        cont;
  logic                        is_space;
  logic                        is_nl;
  logic [3:0]                  digit;
  logic [elx_pkg::VALUE_W-1:0] acc_base;
  logic [elx_pkg::VALUE_W+3:0] acc_sum;
  logic [elx_pkg::VALUE_W-1:0] acc_upd;
  logic                        ovf_upd;
  logic [NB-1:0]               buf_upd;
  logic [elx_pkg::LEN_W-1:0]   cnt_upd;
  logic                        trunc_upd;
  logic                        flush_a;
  logic                        sym_hit;
  logic                        eos_hit;
  elx_pkg::token_kind_t        sym_kind;
  elx_pkg::token_t             old_tok;
  elx_pkg::token_t             new_tok;
  elx_pkg::token_t             sym_tok;

  assign accept   = in_valid & q_stat.room2;
  assign in_stall = ~q_stat.room2;

  // Byte classification
  always_comb begin
    if (in_char_code >= elx_pkg::CH_0 && in_char_code <= elx_pkg::CH_9) begin
      cls = elx_pkg::RUN_NUM;
    end else if (in_char_code >= elx_pkg::CH_LA && in_char_code <= elx_pkg::CH_LZ) begin
      cls = elx_pkg::RUN_LOWER;
    end else if (in_char_code >= elx_pkg::CH_UA && in_char_code <= elx_pkg::CH_UZ) begin
      cls = elx_pkg::RUN_UPPER;
    end else begin
      cls = elx_pkg::RUN_NONE;
    end
  end

  assign cont     = (cls != elx_pkg::RUN_NONE) && (cls == mode_r);
  assign is_space = (in_char_code == elx_pkg::CH_SPACE);
  assign is_nl    = (in_char_code == elx_pkg::CH_NL);
  assign digit    = 4'(in_char_code - elx_pkg::CH_0);

  // Decimal accumulate: acc*10 + d as shift-add, saturating
  assign acc_base = cont ? acc_r : '0;
  assign acc_sum  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                  + {31'd0, digit};
  always_comb begin
    if (acc_sum > (elx_pkg::VALUE_W + 4)'(elx_pkg::VALUE_MAX)) begin
      acc_upd = elx_pkg::VALUE_MAX;
      ovf_upd = 1'b1;
    end else begin
      acc_upd = acc_sum[elx_pkg::VALUE_W-1:0];
      ovf_upd = cont & ovf_r;
    end
  end

  // Name append into the byte lane at the current count
  always_comb begin
    buf_upd   = cont ? buf_r : '0;
    cnt_upd   = cont ? cnt_r : '0;
    trunc_upd = cont & trunc_r;
    if (cnt_upd < elx_pkg::LEN_W'(MAX_NAME_CHARS)) begin
      for (int i = 0; i < MAX_NAME_CHARS; i++) begin
        if (cnt_upd == elx_pkg::LEN_W'(i)) begin
          buf_upd[8*i +: 8] = in_char_code;
        end
      end
      cnt_upd = cnt_upd + 1'b1;
    end else begin
      trunc_upd = 1'b1;
    end
  end

  // Run state after this byte
  always_comb begin
    mid_mode  = cls;
    mid_acc   = '0;
    mid_ovf   = 1'b0;
    mid_buf   = '0;
    mid_cnt   = '0;
    mid_trunc = 1'b0;
    if (cls == elx_pkg::RUN_NUM) begin
      mid_acc = acc_upd;
      mid_ovf = ovf_upd;
    end else if (cls != elx_pkg::RUN_NONE) begin
      mid_buf   = buf_upd;
      mid_cnt   = cnt_upd;
      mid_trunc = trunc_upd;
    end
  end

  // Next state
  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    trunc_nxt = trunc_r;
    line_nxt  = line_r;
    if (accept) begin
      if (in_end_of_source) begin
        mode_nxt  = elx_pkg::RUN_NONE;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        buf_nxt   = '0;
        cnt_nxt   = '0;
        trunc_nxt = 1'b0;
      end else begin
        mode_nxt  = mid_mode;
        acc_nxt   = mid_acc;
        ovf_nxt   = mid_ovf;
        buf_nxt   = mid_buf;
        cnt_nxt   = mid_cnt;
        trunc_nxt = mid_trunc;
      end
      if (is_nl && line_r != {LW{1'b1}}) begin
        line_nxt = line_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= elx_pkg::RUN_NONE;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      buf_r   <= '0;
      cnt_r   <= '0;
      trunc_r <= 1'b0;
      line_r  <= LW'(1);
    end else begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      trunc_r <= trunc_nxt;
      line_r  <= line_nxt;
    end
  end

  // Token for a run that is being closed
  function automatic elx_pkg::token_t run_token(
    input elx_pkg::run_mode_t          m,
    input logic [elx_pkg::VALUE_W-1:0] a,
    input logic                        o,
    input logic [NB-1:0]               b,
    input logic [elx_pkg::LEN_W-1:0]   n,
    input logic                        t,
    input logic [LW-1:0]               ln
  );
    elx_pkg::token_t tk;
    tk      = '0;
    tk.line = elx_pkg::LINE_W'(ln);
    unique case (m)
      elx_pkg::RUN_NUM: begin
        tk.kind  = elx_pkg::TK_NUMBER;
        tk.value = a;
        tk.ovf   = o;
      end
      elx_pkg::RUN_LOWER: begin
        if (!t && n == elx_pkg::KW_PRINT_LEN
            && elx_pkg::NAME_W'(b) == elx_pkg::KW_PRINT) begin
          tk.kind = elx_pkg::TK_PRINT;
        end else if (!t && n == elx_pkg::KW_READ_LEN
                     && elx_pkg::NAME_W'(b) == elx_pkg::KW_READ) begin
          tk.kind = elx_pkg::TK_READ;
        end else begin
          tk.kind  = elx_pkg::TK_VARIABLE;
          tk.name  = elx_pkg::NAME_W'(b);
          tk.len   = n;
          tk.trunc = t;
        end
      end
      elx_pkg::RUN_UPPER: begin
        tk.kind  = elx_pkg::TK_FUNCTION;
        tk.name  = elx_pkg::NAME_W'(b);
        tk.len   = n;
        tk.trunc = t;
      end
      default: tk.kind = elx_pkg::TK_ERROR;
    endcase
    return tk;
  endfunction

  // Single-character symbol decode
  always_comb begin
    unique case (in_char_code)
      elx_pkg::CH_LPAREN: sym_kind = elx_pkg::TK_LPAREN;
      elx_pkg::CH_RPAREN: sym_kind = elx_pkg::TK_RPAREN;
      elx_pkg::CH_STAR:   sym_kind = elx_pkg::TK_MUL;
      elx_pkg::CH_SLASH:  sym_kind = elx_pkg::TK_DIV;
      elx_pkg::CH_PLUS:   sym_kind = elx_pkg::TK_ADD;
      elx_pkg::CH_MINUS:  sym_kind = elx_pkg::TK_SUB;
      elx_pkg::CH_PCT:    sym_kind = elx_pkg::TK_MOD;
      elx_pkg::CH_EQ:     sym_kind = elx_pkg::TK_ASSIGN;
      default:            sym_kind = elx_pkg::TK_ERROR;
    endcase
  end

  assign flush_a = ~cont && (mode_r != elx_pkg::RUN_NONE);
  assign sym_hit = (cls == elx_pkg::RUN_NONE) && ~is_space && ~is_nl;
  assign eos_hit = in_end_of_source && (mid_mode != elx_pkg::RUN_NONE);

  // Token outputs: closed run first, then the byte's own token or the flush
  always_comb begin
    old_tok      = run_token(mode_r, acc_r, ovf_r, buf_r, cnt_r, trunc_r, line_r);
    new_tok      = run_token(mid_mode, mid_acc, mid_ovf, mid_buf, mid_cnt, mid_trunc,
                             line_r);
    sym_tok      = '0;
    sym_tok.kind = sym_kind;
    sym_tok.line = elx_pkg::LINE_W'(line_r);

    push.push0 = accept & (flush_a | sym_hit | eos_hit);
    push.push1 = accept & flush_a & (sym_hit | eos_hit);

    if (flush_a) begin
      push.tok0 = old_tok;
    end else if (sym_hit) begin
      push.tok0 = sym_tok;
    end else begin
      push.tok0 = new_tok;
    end
    push.tok0.last = ~(flush_a & (sym_hit | eos_hit));

    push.tok1      = sym_hit ? sym_tok : new_tok;
    push.tok1.last = 1'b1;
  end

endmodule

`default_nettype wire

// ===== sv/elx_queue.sv =====
// Token queue between front and back end: two writes, one read a cycle.
// Uses elx_pkg for the token and status types.
`default_nettype none

module elx_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  elx_pkg::push_t       push,
  input  logic                 pop,
  output elx_pkg::token_t      head,
  output elx_pkg::queue_stat_t q_stat
);

  elx_pkg::token_t               mem_r [elx_pkg::Q_DEPTH];
  logic [elx_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [elx_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [elx_pkg::Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [elx_pkg::Q_PTR_W-1:0]   wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + elx_pkg::Q_PTR_W'(push.push0)
               + elx_pkg::Q_PTR_W'(push.push1);
    rd_ptr_nxt = rd_ptr_r + elx_pkg::Q_PTR_W'(pop);
    cnt_nxt    = cnt_r + elx_pkg::Q_CNT_W'(push.push0)
               + elx_pkg::Q_CNT_W'(push.push1) - elx_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.tok0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_p1] <= push.tok1;
    end
  end

  assign head             = mem_r[rd_ptr_r];
  assign q_stat.not_empty = (cnt_r != '0);
  assign q_stat.room2     = (cnt_r <= elx_pkg::Q_CNT_W'(elx_pkg::Q_DEPTH - 2));

endmodule

`default_nettype wire

// ===== sv/elx_back.sv =====
// Back end: output register that pops the token queue and drives the
// result port. Uses elx_pkg.
`default_nettype none

module elx_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  elx_pkg::token_t      head,
  input  elx_pkg::queue_stat_t q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_token_kind,
  output logic [30:0]          out_number_value,
  output logic [63:0]          out_name_chars,
  output logic [3:0]           out_name_length,
  output logic                 out_name_truncated,
  output logic                 out_number_overflow,
  output logic [15:0]          out_line_number,
  output logic                 out_last_of_run
);

  logic            valid_r, valid_nxt;
  elx_pkg::token_t tok_r;

  // Load when the register is empty or being taken
  assign pop       = q_stat.not_empty & (~valid_r | ~out_stall);
  assign valid_nxt = pop | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tok_r <= head;
    end
  end

  assign out_valid           = valid_r;
  assign out_token_kind      = tok_r.kind;
  assign out_number_value    = tok_r.value;
  assign out_name_chars      = tok_r.name;
  assign out_name_length     = tok_r.len;
  assign out_name_truncated  = tok_r.trunc;
  assign out_number_overflow = tok_r.ovf;
  assign out_line_number     = tok_r.line;
  assign out_last_of_run     = tok_r.last;

endmodule

`default_nettype wire

// ===== sv/expression_lexer_core.sv =====
// Expression lexer top level: front end, token queue, output register.
// A token passes through the token queue and then the output register.
// Throughput: one byte per cycle while each byte yields at most one token and
// out_stall is low; the single output register drains one token per cycle, so
// a byte that closes a run and emits its own token puts two tokens through it.
// Reset: no pending run, line counter at one, token queue and output empty.
`default_nettype none

module expression_lexer_core #(
  parameter int MAX_NAME_CHARS = 8,
  parameter int LINE_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [30:0] out_number_value,
  output logic [63:0] out_name_chars,
  output logic [3:0]  out_name_length,
  output logic        out_name_truncated,
  output logic        out_number_overflow,
  output logic [15:0] out_line_number,
  output logic        out_last_of_run
);

  elx_pkg::push_t       push;
  elx_pkg::queue_stat_t q_stat;
  elx_pkg::token_t      head;
  logic                 pop;

  elx_front #(
    .MAX_NAME_CHARS (MAX_NAME_CHARS),
    .LINE_BITS      (LINE_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_source (in_end_of_source),
    .q_stat           (q_stat),
    .push             (push)
  );

  elx_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  elx_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .q_stat              (q_stat),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_number_value    (out_number_value),
    .out_name_chars      (out_name_chars),
    .out_name_length     (out_name_length),
    .out_name_truncated  (out_name_truncated),
    .out_number_overflow (out_number_overflow),
    .out_line_number     (out_line_number),
    .out_last_of_run     (out_last_of_run)
  );

endmodule

`default_nettype wire

// ===== tb/sv/expression_lexer_token_check.sv =====
`timescale 1ns / 100ps
// Token checker for the expression lexer: watches the byte and token channels,
// predicts every token from the accepted bytes and compares field by field.
// Depends on elx_pkg for the token kinds, field widths and character codes.

module expression_lexer_token_check #(
  parameter int MAX_NAME_CHARS = 8,
  parameter int LINE_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_source,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_token_kind,
  input  logic [30:0] out_number_value,
  input  logic [63:0] out_name_chars,
  input  logic [3:0]  out_name_length,
  input  logic        out_name_truncated,
  input  logic        out_number_overflow,
  input  logic [15:0] out_line_number,
  input  logic        out_last_of_run,
  output int          mismatch_count,
  output int          tokens_pending
);

  // Line counter stops at the smaller of the counter range and the port range
  localparam logic [elx_pkg::LINE_W-1:0] LINE_CAP =
    (LINE_BITS >= elx_pkg::LINE_W) ? '1
                                   : elx_pkg::LINE_W'((64'd1 << LINE_BITS) - 1);

  // Predicted lexer state
  elx_pkg::run_mode_t          pend_mode;
  logic [elx_pkg::VALUE_W-1:0] pend_value;
  logic [elx_pkg::NAME_W-1:0]  pend_name;
  logic [elx_pkg::LEN_W-1:0]   pend_len;
  logic                        pend_trunc;
  logic                        pend_ovf;
  logic [elx_pkg::LINE_W-1:0]  cur_line;

  elx_pkg::token_t tokens_due[$];
  int              tokens_seen;

  task automatic push_token(elx_pkg::token_kind_t kind,
                            logic [elx_pkg::VALUE_W-1:0] value,
                            logic [elx_pkg::NAME_W-1:0] name,
                            logic [elx_pkg::LEN_W-1:0] len,
                            logic trunc, logic ovf);
    elx_pkg::token_t t;
    t.kind  = kind;
    t.value = value;
    t.name  = name;
    t.len   = len;
    t.trunc = trunc;
    t.ovf   = ovf;
    t.line  = cur_line;
    t.last  = 1'b0;
    tokens_due.push_back(t);
  endtask

  // Emit the pending run, if any, and clear it
  task automatic flush_run();
    case (pend_mode)
      elx_pkg::RUN_NUM:
        push_token(elx_pkg::TK_NUMBER, pend_value, '0, '0, 1'b0, pend_ovf);
      elx_pkg::RUN_LOWER: begin
        if (!pend_trunc && pend_len == elx_pkg::KW_PRINT_LEN
            && pend_name == elx_pkg::KW_PRINT)
          push_token(elx_pkg::TK_PRINT, '0, '0, '0, 1'b0, 1'b0);
        else if (!pend_trunc && pend_len == elx_pkg::KW_READ_LEN
                 && pend_name == elx_pkg::KW_READ)
          push_token(elx_pkg::TK_READ, '0, '0, '0, 1'b0, 1'b0);
        else
          push_token(elx_pkg::TK_VARIABLE, '0, pend_name, pend_len, pend_trunc, 1'b0);
      end
      elx_pkg::RUN_UPPER:
        push_token(elx_pkg::TK_FUNCTION, '0, pend_name, pend_len, pend_trunc, 1'b0);
      default: ;
    endcase
    pend_mode  = elx_pkg::RUN_NONE;
    pend_value = '0;
    pend_name  = '0;
    pend_len   = '0;
    pend_trunc = 1'b0;
    pend_ovf   = 1'b0;
  endtask

  // Add one digit or letter to the pending run
  task automatic absorb(elx_pkg::run_mode_t cls, logic [7:0] c);
    logic [34:0] grown;
    if (cls == elx_pkg::RUN_NUM) begin
      grown = {4'd0, pend_value} * 35'd10 + 35'(c - elx_pkg::CH_0);
      if (grown > {4'd0, elx_pkg::VALUE_MAX}) begin
        pend_value = elx_pkg::VALUE_MAX;
        pend_ovf   = 1'b1;
      end else begin
        pend_value = grown[elx_pkg::VALUE_W-1:0];
      end
    end else if (pend_len < MAX_NAME_CHARS) begin
      pend_name = pend_name | (64'(c) << (8 * pend_len));
      pend_len  = pend_len + 1'b1;
    end else begin
      pend_trunc = 1'b1;
    end
  endtask

  // Predict the tokens caused by one accepted byte
  task automatic lex_byte(logic [7:0] c, logic eos);
    elx_pkg::run_mode_t   cls;
    elx_pkg::token_kind_t kind;
    int                   base;
    base = tokens_due.size();
    if (c >= elx_pkg::CH_0 && c <= elx_pkg::CH_9)        cls = elx_pkg::RUN_NUM;
    else if (c >= elx_pkg::CH_LA && c <= elx_pkg::CH_LZ) cls = elx_pkg::RUN_LOWER;
    else if (c >= elx_pkg::CH_UA && c <= elx_pkg::CH_UZ) cls = elx_pkg::RUN_UPPER;
    else                                                 cls = elx_pkg::RUN_NONE;

    if (cls != elx_pkg::RUN_NONE && cls == pend_mode) begin
      absorb(cls, c);
    end else begin
      flush_run();
      if (cls != elx_pkg::RUN_NONE) begin
        pend_mode = cls;
        absorb(cls, c);
      end else if (c == elx_pkg::CH_NL) begin
        if (cur_line < LINE_CAP) cur_line = cur_line + 1'b1;
      end else if (c != elx_pkg::CH_SPACE) begin
        case (c)
          elx_pkg::CH_LPAREN: kind = elx_pkg::TK_LPAREN;
          elx_pkg::CH_RPAREN: kind = elx_pkg::TK_RPAREN;
          elx_pkg::CH_STAR:   kind = elx_pkg::TK_MUL;
          elx_pkg::CH_SLASH:  kind = elx_pkg::TK_DIV;
          elx_pkg::CH_PLUS:   kind = elx_pkg::TK_ADD;
          elx_pkg::CH_MINUS:  kind = elx_pkg::TK_SUB;
          elx_pkg::CH_PCT:    kind = elx_pkg::TK_MOD;
          elx_pkg::CH_EQ:     kind = elx_pkg::TK_ASSIGN;
          default:            kind = elx_pkg::TK_ERROR;
        endcase
        push_token(kind, '0, '0, '0, 1'b0, 1'b0);
      end
    end
    if (eos) flush_run();
    // final token of this byte carries the marker
    if (tokens_due.size() > base) tokens_due[tokens_due.size() - 1].last = 1'b1;
  endtask

  task automatic compare_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: token %0d %s expected %0h actual %0h",
               $time, tokens_seen, fname, exp_v, act_v);
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    elx_pkg::token_t exp_tok;
    if (!rst_n) begin
      pend_mode      = elx_pkg::RUN_NONE;
      pend_value     = '0;
      pend_name      = '0;
      pend_len       = '0;
      pend_trunc     = 1'b0;
      pend_ovf       = 1'b0;
      cur_line       = elx_pkg::LINE_W'(1);
      tokens_due.delete();
      tokens_seen    = 0;
      mismatch_count = 0;
    end else begin
      if (in_valid && !in_stall) lex_byte(in_char_code, in_end_of_source);
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: token %0d unexpected, expected none actual kind %0d",
                   $time, tokens_seen, out_token_kind);
        end else begin
          exp_tok = tokens_due.pop_front();
          compare_field("kind",     64'(exp_tok.kind),  64'(out_token_kind));
          compare_field("value",    64'(exp_tok.value), 64'(out_number_value));
          compare_field("name",     exp_tok.name,       out_name_chars);
          compare_field("length",   64'(exp_tok.len),   64'(out_name_length));
          compare_field("truncated", 64'(exp_tok.trunc), 64'(out_name_truncated));
          compare_field("overflow", 64'(exp_tok.ovf),   64'(out_number_overflow));
          compare_field("line",     64'(exp_tok.line),  64'(out_line_number));
          compare_field("last",     64'(exp_tok.last),  64'(out_last_of_run));
        end
        tokens_seen++;
      end
    end
    tokens_pending = tokens_due.size();
  end

endmodule

// ===== tb/sv/expression_lexer_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for expression_lexer_core: clock, reset, byte stimulus and
// token-side stall; checking is done by expression_lexer_token_check.
// Depends on elx_pkg, expression_lexer_core and expression_lexer_token_check.

module expression_lexer_core_tb;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int IDLE_PCT      = 22;
  localparam int CALM_FIRST    = 420;
  localparam int CALM_LAST     = 720;
  localparam int HOLD_START    = 200;
  localparam int HOLD_LEN      = 90;
  localparam int LINE_RUN      = 40;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [7:0] code;
    logic       eos;
  } src_byte_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        in_end_of_source;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_token_kind;
  logic [30:0] out_number_value;
  logic [63:0] out_name_chars;
  logic [3:0]  out_name_length;
  logic        out_name_truncated;
  logic        out_number_overflow;
  logic [15:0] out_line_number;
  logic        out_last_of_run;
  logic        calm;
  int          mismatch_count;
  int          tokens_pending;
  int          cycle_count;

  src_byte_t stim_q[$];

  always #HALF_PERIOD clk = ~clk;

  expression_lexer_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_code        (in_char_code),
    .in_end_of_source    (in_end_of_source),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_number_value    (out_number_value),
    .out_name_chars      (out_name_chars),
    .out_name_length     (out_name_length),
    .out_name_truncated  (out_name_truncated),
    .out_number_overflow (out_number_overflow),
    .out_line_number     (out_line_number),
    .out_last_of_run     (out_last_of_run)
  );

  expression_lexer_token_check token_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_code        (in_char_code),
    .in_end_of_source    (in_end_of_source),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_number_value    (out_number_value),
    .out_name_chars      (out_name_chars),
    .out_name_length     (out_name_length),
    .out_name_truncated  (out_name_truncated),
    .out_number_overflow (out_number_overflow),
    .out_line_number     (out_line_number),
    .out_last_of_run     (out_last_of_run),
    .mismatch_count      (mismatch_count),
    .tokens_pending      (tokens_pending)
  );

  task automatic put_byte(logic [7:0] c, logic eos);
    src_byte_t b;
    b.code = c;
    b.eos  = eos;
    stim_q.push_back(b);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(8'(s[i]), 1'b0);
  endtask

  function automatic logic [7:0] symbol_code(int idx);
    case (idx)
      0:       return elx_pkg::CH_LPAREN;
      1:       return elx_pkg::CH_RPAREN;
      2:       return elx_pkg::CH_STAR;
      3:       return elx_pkg::CH_SLASH;
      4:       return elx_pkg::CH_PLUS;
      5:       return elx_pkg::CH_MINUS;
      6:       return elx_pkg::CH_PCT;
      default: return elx_pkg::CH_EQ;
    endcase
  endfunction

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Token side: random stall, one long hold-off, none during the calm stretch
  initial begin
    int rx_cycles;
    int hold_left;
    rx_cycles = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n) rx_cycles++;
      if (rx_cycles == HOLD_START) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Byte side: build the source, then send one word per accepted handshake
  initial begin
    int   pick;
    int   len;
    int   base;
    logic quiet;
    string kw;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_char_code     = 8'h00;
    in_end_of_source = 1'b0;
    calm             = 1'b0;

    // Directed: every symbol, both keywords, space, newline, each run class,
    // unknown bytes at both ends of the byte range, and an end-of-source byte
    // that closes one run while starting another
    put_text("(read)*/+-%=print 7\nZ");
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(elx_pkg::CH_LZ, 1'b0);
    put_byte(elx_pkg::CH_0 + 8'd5, 1'b1);
    base = stim_q.size();

    // Random source text built from well-formed fragments plus noise
    while (stim_q.size() < base + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        repeat (len) put_byte(elx_pkg::CH_0 + 8'($urandom_range(0, 9)), 1'b0);
      end else if (pick < 23) begin
        // saturation boundary
        put_text(($urandom_range(0, 1) == 1) ? "2147483647" : "2147483648");
      end else if (pick < 40) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 11) : $urandom_range(1, 4);
        repeat (len) put_byte(elx_pkg::CH_LA + 8'($urandom_range(0, 25)), 1'b0);
      end else if (pick < 52) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 11) : $urandom_range(1, 4);
        repeat (len) put_byte(elx_pkg::CH_UA + 8'($urandom_range(0, 25)), 1'b0);
      end else if (pick < 62) begin
        case ($urandom_range(0, 6))
          0, 1:    kw = "print";
          2, 3:    kw = "read";
          4:       kw = "prin";
          5:       kw = "reads";
          default: kw = "printread";
        endcase
        put_text(kw);
      end else if (pick < 78) begin
        put_byte(symbol_code($urandom_range(0, 7)), 1'b0);
      end else if (pick < 88) begin
        put_byte(($urandom_range(0, 2) == 0) ? elx_pkg::CH_NL : elx_pkg::CH_SPACE, 1'b0);
      end else begin
        put_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      // separator, often none so that runs abut
      case ($urandom_range(0, 3))
        0:       put_byte(elx_pkg::CH_SPACE, 1'b0);
        1:       put_byte(symbol_code($urandom_range(0, 7)), 1'b0);
        default: ;
      endcase
      if ($urandom_range(0, 99) < 5) stim_q[stim_q.size() - 1].eos = 1'b1;
    end

    // A burst of newlines, then a few tokens on the last line
    repeat (LINE_RUN) put_byte(elx_pkg::CH_NL, 1'b0);
    put_text("x+1");
    put_byte(elx_pkg::CH_UA, 1'b1);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_q[i]) begin
      quiet = (i >= base + CALM_FIRST) && (i < base + CALM_LAST);
      calm <= quiet;
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid         <= 1'b1;
      in_char_code     <= stim_q[i].code;
      in_end_of_source <= stim_q[i].eos;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (tokens_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
